>>> design/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window median filter
// Field widths, default window depth and the per-item update command.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int SAMPLE_W       = 32;   // input sample width
    localparam int RESULT_W       = 33;   // doubled median width
    localparam int CFG_W          = 7;    // window_size register width
    localparam int S_TDATA_W      = 32;   // sample
    localparam int M_TDATA_W      = 40;   // median_twice, zero padded to bytes
    localparam int WINDOW_MAX_DEF = 64;

    // Update command broadcast to every cell of the sorted row
    typedef struct packed {
        logic                       en;         // update the row this cycle
        logic                       full;       // remove oldest and insert new
        logic                       ins_right;  // new sample >= removed sample
        logic signed [SAMPLE_W-1:0] smp;        // sample entering the window
        logic signed [SAMPLE_W-1:0] old;        // sample leaving the window
    } t_cell_ctrl;

endpackage

>>> design/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted sample row
// Holds one value; shifts left, right, takes the new sample or keeps its own.
// ----------------------------------------------------------------------------
module swm_cell import swm_pkg::*; (
    input  logic                       i_clk,
    input  t_cell_ctrl                 i_ctrl,
    input  logic                       i_has_left,
    input  logic signed [SAMPLE_W-1:0] i_left_val,
    input  logic                       i_left_ge_o,
    input  logic                       i_left_gt_s,
    input  logic                       i_right_live,
    input  logic signed [SAMPLE_W-1:0] i_right_val,
    input  logic                       i_right_gt_s,
    input  logic                       i_at_fill,
    output logic signed [SAMPLE_W-1:0] o_val,
    output logic                       o_ge_o,
    output logic                       o_gt_s
);

    logic signed [SAMPLE_W-1:0] r_val;
    logic signed [SAMPLE_W-1:0] n_val;
    logic signed [SAMPLE_W-1:0] smp;
    logic signed [SAMPLE_W-1:0] old;
    logic                       ge_o;
    logic                       gt_s;
    logic                       take_left;

    assign smp       = $signed(i_ctrl.smp);
    assign old       = $signed(i_ctrl.old);
    assign ge_o      = (r_val >= old);
    assign gt_s      = (r_val > smp);
    assign take_left = i_has_left && i_left_gt_s;

    always_comb begin
        n_val = r_val;
        if (!i_ctrl.full) begin
            // fill: insert only, larger values move one slot right
            if (take_left) begin
                n_val = i_left_val;
            end else if (i_at_fill || gt_s) begin
                n_val = smp;
            end
        end else if (i_ctrl.ins_right) begin
            // cells from the removed one up close the gap, new sample lands
            if (ge_o) begin
                if (i_right_live && !i_right_gt_s) begin
                    n_val = i_right_val;
                end else if (!gt_s) begin
                    n_val = smp;
                end
            end
        end else begin
            // cells up to the removed one open a gap from below
            if (!i_has_left || !i_left_ge_o) begin
                if (take_left) begin
                    n_val = i_left_val;
                end else if (gt_s) begin
                    n_val = smp;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_val <= n_val;
        end
    end

    assign o_val  = r_val;
    assign o_ge_o = ge_o;
    assign o_gt_s = gt_s;

endmodule

>>> design/swm_chain.sv
// ----------------------------------------------------------------------------
// swm_chain: row of sorted cells with median tap
// Cells trade values with their neighbors; the two middle slots are registered.
// ----------------------------------------------------------------------------
module swm_chain import swm_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                                     i_clk,
    input  t_cell_ctrl                               i_ctrl,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]          i_k,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]          i_fill,
    input  logic                                     i_mid_load,
    output logic signed [SAMPLE_W-1:0]               o_lo,
    output logic signed [SAMPLE_W-1:0]               o_hi
);

    localparam int KW = $clog2(WINDOW_MAX + 1);
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic signed [SAMPLE_W-1:0] w_val  [WINDOW_MAX];
    logic                       w_ge_o [WINDOW_MAX];
    logic                       w_gt_s [WINDOW_MAX];

    logic [KW-1:0] k_m1;
    logic [KW-1:0] lo_sh;
    logic [KW-1:0] hi_sh;
    logic [AW-1:0] lo_idx;
    logic [AW-1:0] hi_idx;

    logic signed [SAMPLE_W-1:0] r_lo;
    logic signed [SAMPLE_W-1:0] r_hi;

    for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
        logic                       has_left;
        logic signed [SAMPLE_W-1:0] left_val;
        logic                       left_ge_o;
        logic                       left_gt_s;
        logic signed [SAMPLE_W-1:0] right_val;
        logic                       right_gt_s;
        logic                       right_live;
        logic                       at_fill;

        if (gi == 0) begin : g_head
            assign has_left  = 1'b0;
            assign left_val  = '0;
            assign left_ge_o = 1'b0;
            assign left_gt_s = 1'b0;
        end else begin : g_mid_l
            assign has_left  = 1'b1;
            assign left_val  = w_val[gi-1];
            assign left_ge_o = w_ge_o[gi-1];
            assign left_gt_s = w_gt_s[gi-1];
        end

        if (gi == WINDOW_MAX - 1) begin : g_tail
            assign right_val  = '0;
            assign right_gt_s = 1'b1;
            assign right_live = 1'b0;
        end else begin : g_mid_r
            assign right_val  = w_val[gi+1];
            assign right_gt_s = w_gt_s[gi+1];
            assign right_live = (KW'(gi + 1) < i_k);
        end

        assign at_fill = (i_fill == KW'(gi));

        swm_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (i_ctrl),
            .i_has_left   (has_left),
            .i_left_val   (left_val),
            .i_left_ge_o  (left_ge_o),
            .i_left_gt_s  (left_gt_s),
            .i_right_live (right_live),
            .i_right_val  (right_val),
            .i_right_gt_s (right_gt_s),
            .i_at_fill    (at_fill),
            .o_val        (w_val[gi]),
            .o_ge_o       (w_ge_o[gi]),
            .o_gt_s       (w_gt_s[gi])
        );
    end

    // lower middle at (k-1)/2, upper middle at k/2
    assign k_m1   = i_k - KW'(1);
    assign lo_sh  = k_m1 >> 1;
    assign hi_sh  = i_k >> 1;
    assign lo_idx = lo_sh[AW-1:0];
    assign hi_idx = hi_sh[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_mid_load) begin
            r_lo <= w_val[lo_idx];
            r_hi <= w_val[hi_idx];
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

>>> design/sliding_window_median.sv
// ----------------------------------------------------------------------------
// sliding_window_median: doubled median over the last window_size samples
// Slave stream: tdata = sample (signed 32), tuser = first (restart window).
// Master stream: tdata = median_twice (signed 33, bits 39:33 zero).
// Config channel: valid/ready write of window_size (7 bits); 0 acts as 1,
// values above WINDOW_MAX saturate. Every write restarts the window.
// Each item enters a row of sorted cells that, once the window is full,
// removes the oldest sample and inserts the new one in one parallel shift.
// Until window_size samples have arrived no result is sent; after that every
// item gives one result, the sum of the two middle sorted values.
// Steps per item: ring read at accept, cell update, middle tap, output
// load, and the result is registered. An item holds the block through all
// of them (up to the cell update while the window is still filling).
// The output register frees the block while a result waits; if the receiver
// stalls, the next result waits in the load step until the register empties.
// Reset clears the window and sets window_size to 1; ring and cells are not
// cleared, entries are only read after being written.
// ----------------------------------------------------------------------------
module sliding_window_median import swm_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_W-1:0]      i_cfg_data,    // window_size
    // sample stream in
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,     // [31:0] sample
    input  logic [0:0]            i_s_tuser,     // [0] first
    // result stream out
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata      // [32:0] median_twice
);

    localparam int KW = $clog2(WINDOW_MAX + 1);
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_MID,
        S_OUT
    } t_state;

    t_state                     r_state;
    logic [CFG_W-1:0]           r_win;
    logic [KW-1:0]              r_fill;
    logic [AW-1:0]              r_ptr;
    logic                       r_full_mode;
    logic signed [SAMPLE_W-1:0] r_smp;
    logic signed [SAMPLE_W-1:0] r_old;
    logic                       r_out_valid;
    logic [RESULT_W-1:0]        r_out_data;

    // arrival order ring
    logic [SAMPLE_W-1:0]        r_ring [WINDOW_MAX];

    logic [KW-1:0]              k;
    logic                       s_acc;
    logic                       cfg_acc;
    logic [KW-1:0]              fill_e;
    logic [AW-1:0]              ptr_e;
    logic [KW-1:0]              ptr_next;
    logic [KW-1:0]              fill_next;
    logic                       produce;
    logic                       out_free;
    logic                       ring_we;
    logic [AW-1:0]              ring_wa;
    t_cell_ctrl                 ctrl;
    logic signed [SAMPLE_W-1:0] mid_lo;
    logic signed [SAMPLE_W-1:0] mid_hi;
    logic [RESULT_W-1:0]        sum;

    // effective window length
    always_comb begin
        if (r_win == '0) begin
            k = KW'(1);
        end else if (32'(r_win) > WINDOW_MAX) begin
            k = KW'(WINDOW_MAX);
        end else begin
            k = KW'(r_win);
        end
    end

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_s_tready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign s_acc       = i_s_tvalid && o_s_tready;

    // restart on first, drop stale counts after a window change
    assign fill_e = (i_s_tuser[0] || (r_fill > k)) ? '0 : r_fill;
    assign ptr_e  = (i_s_tuser[0] || (KW'(r_ptr) >= k)) ? '0 : r_ptr;

    assign ptr_next  = KW'(r_ptr) + KW'(1);
    assign fill_next = r_fill + KW'(1);
    assign produce   = r_full_mode || (fill_next == k);
    assign out_free  = !r_out_valid || i_m_tready;

    assign ctrl.en        = (r_state == S_UPD);
    assign ctrl.full      = r_full_mode;
    assign ctrl.ins_right = (r_smp >= r_old);
    assign ctrl.smp       = r_smp;
    assign ctrl.old       = r_old;

    assign ring_we = (r_state == S_UPD);
    assign ring_wa = r_full_mode ? r_ptr : r_fill[AW-1:0];

    swm_chain #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_chain (
        .i_clk      (i_clk),
        .i_ctrl     (ctrl),
        .i_k        (k),
        .i_fill     (r_fill),
        .i_mid_load (r_state == S_MID),
        .o_lo       (mid_lo),
        .o_hi       (mid_hi)
    );

    assign sum = RESULT_W'(mid_lo) + RESULT_W'(mid_hi);

    // ring: read the leaving sample at accept, write the new one at update
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_old <= $signed(r_ring[ptr_e]);
        end
        if (ring_we) begin
            r_ring[ring_wa] <= r_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win       <= CFG_W'(1);
            r_fill      <= '0;
            r_ptr       <= '0;
            r_full_mode <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // in the load step the register is refilled instead
            if (r_out_valid && i_m_tready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cfg_acc) begin
                        r_win  <= i_cfg_data;
                        r_fill <= '0;
                        r_ptr  <= '0;
                    end else if (s_acc) begin
                        r_smp       <= $signed(i_s_tdata[SAMPLE_W-1:0]);
                        r_fill      <= fill_e;
                        r_ptr       <= ptr_e;
                        r_full_mode <= (fill_e == k);
                        r_state     <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (r_full_mode) begin
                        r_ptr <= (ptr_next == k) ? '0 : ptr_next[AW-1:0];
                    end else begin
                        r_fill <= fill_next;
                        r_ptr  <= '0;
                    end
                    r_state <= produce ? S_MID : S_IDLE;
                end
                S_MID: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_data  <= sum;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'(r_out_data);

endmodule

>>> design/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker: port-level checks for the sliding window median filter
// Watches handshakes and result timing; bound to the top level.
// ----------------------------------------------------------------------------
module swm_checker import swm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_s_tvalid,
    input  logic                  o_s_tready,
    input  logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [M_TDATA_W-1:0]  o_m_tdata
);

    logic s_acc;

    assign s_acc = i_s_tvalid && o_s_tready;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // one item at a time
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_tready)
        else $error("item accepted while busy");

    // tvalid rises only for an item accepted through the update, tap and load steps
    a_result_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(s_acc, 4))
        else $error("result without matching item");

    // config write and item never share a cycle
    a_cfg_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> !o_s_tready)
        else $error("item taken during config write");

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sliding window median filter
// Feeds signed samples over the slave stream and rewrites window_size between
// phases. Each accepted sample goes through a queue-based window predictor,
// and every result on the master stream is matched in order against it.
// ----------------------------------------------------------------------------
module tb;
    import swm_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RST_CYCLES   = 10;
    localparam int ITEM_TARGET  = 1900;
    localparam int SETTLE_CYC   = 16;          // block latency plus a margin
    localparam int TAIL_JOBS    = 150;         // no idling once this few jobs remain
    localparam int MAX_REPORTS  = 10;
    localparam int WATCHDOG     = 400_000 * 2 * CLK_HALF;

    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 32'sh8000_0000;

    // work the driver pulls from its queue
    typedef enum logic [1:0] {
        JOB_SAMPLE,     // one sample item
        JOB_DRAIN,      // wait until every expected median is back, then settle
        JOB_WINDOW      // write window_size
    } t_job_kind;

    typedef struct {
        t_job_kind                  kind;
        logic signed [SAMPLE_W-1:0] smp;
        logic                       first;
        logic [CFG_W-1:0]           win;
    } t_job;

    // ------------------------------------------------------------------ DUT io
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_W-1:0]      i_cfg_data  = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata   = '0;    // [31:0] sample
    logic [0:0]            i_s_tuser   = '0;    // [0] first
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;           // [32:0] median_twice

    sliding_window_median i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // ------------------------------------------------------------------ clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------- bench state
    t_job                        job_q[$];        // pending sample items and phase jobs
    logic signed [RESULT_W-1:0]  median_exp_q[$]; // doubled medians still to come
    int                          err_count = 0;

    // window predictor: samples in arrival order and in ascending order
    logic [CFG_W-1:0]            win_reg = 7'd1;
    logic signed [SAMPLE_W-1:0]  arrival_q[$];
    logic signed [SAMPLE_W-1:0]  ordered_q[$];

    // handshakes seen at the last rising edge, read by the falling-edge drivers
    logic                        s_took   = 1'b0;
    logic                        cfg_took = 1'b0;

    // driver and receiver bookkeeping
    int                          tx_gap    = 0;
    int                          tx_quiet  = 0;
    int                          tx_settle = 0;
    int                          rx_stall  = 0;
    int                          rx_quiet  = 0;
    logic                        nxt_valid;
    logic                        nxt_cfg_valid;
    logic                        nxt_ready;
    t_job                        head;

    // register value 0 acts as 1, values above the row depth saturate
    function automatic int unsigned window_len(logic [CFG_W-1:0] w);
        if (w == '0)
            return 1;
        if (w > WINDOW_MAX_DEF)
            return WINDOW_MAX_DEF;
        return 32'(w);
    endfunction

    // idling only outside the final stretch of the run
    function automatic logic idle_allowed();
        return job_q.size() > TAIL_JOBS;
    endfunction

    task automatic window_clear();
        arrival_q.delete();
        ordered_q.delete();
    endtask

    // Slide one sample into the window; once the window holds K samples,
    // queue the sum of the two middle values (same cell for odd K).
    task automatic slide_window(logic signed [SAMPLE_W-1:0] smp, logic first);
        int unsigned                k;
        int                         pos;
        logic signed [SAMPLE_W-1:0] leaving;
        k = window_len(win_reg);
        if (first)
            window_clear();
        if (arrival_q.size() == k) begin
            leaving = arrival_q.pop_front();
            pos = 0;
            while (ordered_q[pos] != leaving)
                pos++;
            ordered_q.delete(pos);
        end
        arrival_q.insert(arrival_q.size(), smp);
        // stable insert: equal values go after existing ones
        pos = 0;
        while (pos < ordered_q.size() && ordered_q[pos] <= smp)
            pos++;
        ordered_q.insert(pos, smp);
        if (arrival_q.size() == k)
            median_exp_q.insert(median_exp_q.size(),
                RESULT_W'(ordered_q[(k - 1) / 2]) + RESULT_W'(ordered_q[k / 2]));
    endtask

    task automatic report_fault(string what, logic [M_TDATA_W-1:0] want,
                                logic [M_TDATA_W-1:0] got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("mismatch (%s): expected %h, got %h", what, want, got);
    endtask

    // ------------------------------------------------- stimulus helpers
    task automatic add_sample(logic signed [SAMPLE_W-1:0] smp, logic first);
        t_job j;
        j.kind  = JOB_SAMPLE;
        j.smp   = smp;
        j.first = first;
        j.win   = '0;
        job_q.insert(job_q.size(), j);
    endtask

    // pause until the block is idle; with a new window, write it after that
    task automatic add_drain(logic with_window, logic [CFG_W-1:0] w);
        t_job j;
        j.kind  = JOB_DRAIN;
        j.smp   = '0;
        j.first = 1'b0;
        j.win   = w;
        job_q.insert(job_q.size(), j);
        if (with_window) begin
            j.kind = JOB_WINDOW;
            job_q.insert(job_q.size(), j);
        end
    endtask

    // mix of full-range values, extremes, and a narrow band that makes duplicates
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return SMP_MAX;
                    1:       return SMP_MIN;
                    2:       return '0;
                    default: return -1;
                endcase
            end
            1, 2, 3: return $signed(SAMPLE_W'($urandom_range(0, 16))) - 8;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------- sample driver
    // Inputs change on the falling edge. A taken item is dropped and the next
    // job is looked at in the same step, so back-to-back items keep tvalid high.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            nxt_valid     = i_s_tvalid;
            nxt_cfg_valid = i_cfg_valid;
            if (i_s_tvalid && s_took)
                nxt_valid = 1'b0;
            if (i_cfg_valid && cfg_took)
                nxt_cfg_valid = 1'b0;

            if (!nxt_valid && !nxt_cfg_valid) begin
                if (tx_settle != 0) begin
                    tx_settle--;
                end else if (tx_gap != 0) begin
                    tx_gap--;
                end else if (job_q.size() != 0) begin
                    head = job_q[0];
                    case (head.kind)
                        JOB_SAMPLE: begin
                            void'(job_q.pop_front());
                            nxt_valid    = 1'b1;
                            i_s_tdata   <= head.smp;
                            i_s_tuser   <= head.first;
                            // idle bursts follow an item, then a quiet stretch
                            if (tx_quiet != 0) begin
                                tx_quiet--;
                            end else if (idle_allowed() && $urandom_range(0, 4) == 0) begin
                                tx_gap   = $urandom_range(1, 14);
                                tx_quiet = $urandom_range(0, 30);
                            end
                        end
                        JOB_DRAIN: begin
                            // samples that only fill the window give no result,
                            // so the settle time covers their work in flight
                            if (median_exp_q.size() == 0) begin
                                void'(job_q.pop_front());
                                tx_settle = SETTLE_CYC;
                            end
                        end
                        JOB_WINDOW: begin
                            void'(job_q.pop_front());
                            nxt_cfg_valid = 1'b1;
                            i_cfg_data   <= head.win;
                        end
                        default: void'(job_q.pop_front());
                    endcase
                end
            end
            i_s_tvalid  <= nxt_valid;
            i_cfg_valid <= nxt_cfg_valid;
        end
    end

    // ------------------------------------------------------- result receiver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (rx_stall != 0) begin
                nxt_ready = 1'b0;
                rx_stall--;
            end else begin
                nxt_ready = 1'b1;
                if (rx_quiet != 0) begin
                    rx_quiet--;
                end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
                    rx_stall = $urandom_range(1, 14);
                    rx_quiet = $urandom_range(0, 40);
                end
            end
            i_m_tready <= nxt_ready;
        end
    end

    // ------------------------------------------------------- monitor
    // Everything is sampled on the rising edge: the window write and the
    // sample item update the predictor first, then a result is checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                win_reg = i_cfg_data;
                window_clear();
            end
            if (i_s_tvalid && o_s_tready)
                slide_window($signed(i_s_tdata[SAMPLE_W-1:0]), i_s_tuser[0]);
            if (o_m_tvalid && i_m_tready) begin
                if (median_exp_q.size() == 0)
                    report_fault("no result expected", 'x, o_m_tdata);
                else
                    if (o_m_tdata !== M_TDATA_W'(unsigned'(median_exp_q[0])))
                        report_fault("median_twice",
                                     M_TDATA_W'(unsigned'(median_exp_q[0])), o_m_tdata);
                if (median_exp_q.size() != 0)
                    void'(median_exp_q.pop_front());
            end
        end
        s_took   <= i_rst_n && i_s_tvalid && o_s_tready;
        cfg_took <= i_rst_n && i_cfg_valid && o_cfg_ready;
    end

    // ------------------------------------------------------- test sequence
    initial begin
        int               n_items;
        int               n_phase;
        int unsigned      k;
        int               len;
        logic [CFG_W-1:0] w;

        // window 1 from reset: every sample returns twice itself
        add_sample(SMP_MAX, 1'b0);
        add_sample(SMP_MIN, 1'b1);
        add_sample('0,      1'b0);
        add_sample(-1,      1'b1);
        add_sample(1,       1'b0);

        // odd window, duplicates leaving, restart by first in mid-window
        add_drain(1'b1, 7'd3);
        add_sample(5,       1'b0);
        add_sample(-7,      1'b0);   // still filling
        add_sample(5,       1'b0);
        add_sample(5,       1'b0);   // a duplicate leaves
        add_sample(SMP_MIN, 1'b0);
        add_sample(9,       1'b1);   // restart, refill
        add_sample(2,       1'b0);
        add_sample(SMP_MAX, 1'b0);

        // even window: sum of both middles at the extremes
        add_drain(1'b1, 7'd2);
        add_sample(SMP_MAX, 1'b0);
        add_sample(SMP_MAX, 1'b0);
        add_sample(SMP_MIN, 1'b0);
        add_sample(SMP_MIN, 1'b0);
        add_sample(SMP_MAX, 1'b0);

        // window size zero acts as one
        add_drain(1'b1, 7'd0);
        add_sample(-3,      1'b0);
        add_sample(SMP_MIN, 1'b0);
        n_items = 20;

        // random phases: extremes of window_size first, then mostly small windows
        n_phase = 0;
        while (n_items < ITEM_TARGET) begin
            case (n_phase)
                0:       w = 7'd64;
                1:       w = 7'd127;
                2:       w = 7'd0;
                3:       w = 7'd1;
                default: begin
                    case ($urandom_range(0, 11))
                        0:       w = 7'd64;
                        1:       w = CFG_W'($urandom_range(65, 127));
                        2:       w = CFG_W'($urandom_range(9, 63));
                        3:       w = 7'd0;
                        default: w = CFG_W'($urandom_range(1, 8));
                    endcase
                end
            endcase
            add_drain(1'b1, w);
            k   = window_len(w);
            len = k + $urandom_range(8, 50);
            for (int i = 0; i < len; i++)
                add_sample(pick_sample(), $urandom_range(0, 4 * k + 20) == 0);
            n_items += len;
            n_phase++;
            // sometimes hold the sender until everything is out, same window
            if ($urandom_range(0, 3) == 0)
                add_drain(1'b0, '0);
        end

        // hold reset, then release it on a falling edge
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // wait for all items and results, then let the pipe run dry
        while (job_q.size() != 0 || i_s_tvalid || i_cfg_valid || median_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (err_count == 0 && median_exp_q.size() == 0)
            $display("[sliding_window_median] OK");
        else
            $display("[sliding_window_median] ERROR");
        $finish;
    end

    // ------------------------------------------------------- watchdog
    initial begin
        #WATCHDOG;
        $display("[sliding_window_median] ERROR");
        $finish;
    end

endmodule
